[hw/rtl/srcnt_pkg.sv]
// Shared constants, types and controller/datapath interface for the square-free counter.
// Used by srcnt_ctrl, srcnt_dp, the top level and the checker; depends on nothing.
package srcnt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int ROOT_BITS  = (VALUE_BITS + 1) / 2;
  localparam int MU_DEPTH   = 1 << ROOT_BITS;
  localparam int CNT_BITS   = VALUE_BITS + 1;
  localparam int ACC_BITS   = VALUE_BITS + 3;
  localparam int SQ_BITS    = 2 * ROOT_BITS + 2;
  localparam int STEP_BITS  = $clog2(VALUE_BITS);
  localparam int IN_W       = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((CNT_BITS + 7) / 8) * 8;

  // Flag bits of one Moebius table entry
  localparam int MU_ZERO_BIT = 0;
  localparam int MU_NEG_BIT  = 1;
  localparam int MU_COMP_BIT = 2;

  typedef enum logic [1:0] {
    RD_P = 2'd0,
    RD_J = 2'd1,
    RD_D = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    wr_clr;
    logic    wr_tog;
    logic    wr_zero;
    logic    j_step_one;
    logic    j_load_p;
    logic    j_load_psq;
    logic    j_step_p;
    logic    j_step_psq;
    logic    p_init;
    logic    p_inc;
    rd_sel_t rd_sel;
    logic    q_load;
    logic    d_inc;
    logic    div_start;
    logic    div_step;
    logic    acc_update;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic j_end;
    logic p_done;
    logic comp;
    logic psq_fits;
    logic q_stop;
    logic mu_zero;
    logic div_last;
    logic out_busy;
  } dp_sts_t;

endpackage

[hw/rtl/srcnt_dp.sv]
// Datapath: Moebius table memory with sieve counters, square units, twin restoring
// dividers, signed accumulator and output register. Depends on srcnt_pkg.
module srcnt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  srcnt_pkg::dp_cmd_t          cmd,
  output srcnt_pkg::dp_sts_t          sts,
  input  logic [srcnt_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [srcnt_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int V  = srcnt_pkg::VALUE_BITS;
  localparam int R  = srcnt_pkg::ROOT_BITS;
  localparam int SQ = srcnt_pkg::SQ_BITS;
  localparam int AW = srcnt_pkg::ACC_BITS;

  logic [2:0]    mem [srcnt_pkg::MU_DEPTH];
  logic [2:0]    rdata;
  logic [2:0]    wdata;
  logic [R-1:0]  raddr;
  logic          we;

  logic [R:0]    p;
  logic [R:0]    j;
  logic [R:0]    d;
  logic [SQ-1:0] psq;
  logic [SQ-1:0] dsq;

  logic [V-1:0]  lo_in;
  logic [V-1:0]  hi_in;
  logic [V-1:0]  hi;
  logic [V-1:0]  lo1;
  logic          empty;
  logic          special;

  logic [V-1:0]  divisor;
  logic [V-1:0]  qa;
  logic [V-1:0]  qb;
  logic [V-1:0]  ra;
  logic [V-1:0]  rb;
  logic [V:0]    ta;
  logic [V:0]    tb;
  logic [srcnt_pkg::STEP_BITS-1:0] dcnt;
  logic          mu_neg;

  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] diff;

  logic                 out_valid;
  logic [V:0]           out_data;

  assign lo_in = s_axis_tdata[V-1:0];
  assign hi_in = s_axis_tdata[2*V-1:V];

  always_comb begin
    unique case (cmd.rd_sel)
      srcnt_pkg::RD_P: raddr = p[R-1:0];
      srcnt_pkg::RD_J: raddr = j[R-1:0];
      srcnt_pkg::RD_D: raddr = d[R-1:0];
      default:         raddr = d[R-1:0];
    endcase
  end

  always_comb begin
    we    = cmd.wr_clr | cmd.wr_tog | cmd.wr_zero;
    wdata = rdata;
    if (cmd.wr_clr) begin
      wdata = '0;
    end else if (cmd.wr_tog) begin
      wdata[srcnt_pkg::MU_NEG_BIT]  = ~rdata[srcnt_pkg::MU_NEG_BIT];
      wdata[srcnt_pkg::MU_COMP_BIT] = rdata[srcnt_pkg::MU_COMP_BIT] | (j != p);
    end else if (cmd.wr_zero) begin
      wdata[srcnt_pkg::MU_ZERO_BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[j[R-1:0]] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (cmd.j_step_one) begin
      j <= j + (R+1)'(1);
    end else if (cmd.j_load_p) begin
      j <= p;
    end else if (cmd.j_load_psq) begin
      j <= psq[R:0];
    end else if (cmd.j_step_p) begin
      j <= j + p;
    end else if (cmd.j_step_psq) begin
      j <= j + psq[R:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_init) begin
      p <= (R+1)'(2);
    end else if (cmd.p_inc) begin
      p <= p + (R+1)'(1);
    end
    psq <= SQ'(p) * SQ'(p);
    dsq <= SQ'(d) * SQ'(d);
  end

  always_comb begin
    ta = {ra, qa[V-1]};
    tb = {rb, qb[V-1]};
  end

  assign diff = $signed(AW'(qa)) - $signed(AW'(qb));

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      hi      <= hi_in;
      lo1     <= (lo_in == '0) ? '0 : lo_in - V'(1);
      empty   <= lo_in > hi_in;
      special <= (lo_in == '0) && (hi_in < V'(4));
      d       <= (R+1)'(1);
      acc     <= '0;
    end else begin
      if (cmd.d_inc) begin
        d <= d + (R+1)'(1);
      end
      if (cmd.acc_update) begin
        acc <= mu_neg ? acc - diff : acc + diff;
      end
    end
    if (cmd.div_start) begin
      divisor <= dsq[V-1:0];
      qa      <= hi;
      qb      <= lo1;
      ra      <= '0;
      rb      <= '0;
      dcnt    <= srcnt_pkg::STEP_BITS'(V - 1);
      mu_neg  <= rdata[srcnt_pkg::MU_NEG_BIT];
    end else if (cmd.div_step) begin
      if (ta >= {1'b0, divisor}) begin
        ra <= V'(ta - {1'b0, divisor});
        qa <= {qa[V-2:0], 1'b1};
      end else begin
        ra <= ta[V-1:0];
        qa <= {qa[V-2:0], 1'b0};
      end
      if (tb >= {1'b0, divisor}) begin
        rb <= V'(tb - {1'b0, divisor});
        qb <= {qb[V-2:0], 1'b1};
      end else begin
        rb <= tb[V-1:0];
        qb <= {qb[V-2:0], 1'b0};
      end
      dcnt <= dcnt - srcnt_pkg::STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= empty ? '0 : (V+1)'(special) + acc[V:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = srcnt_pkg::OUT_W'(out_data);

  always_comb begin
    sts.j_end    = j[R];
    sts.p_done   = p[R];
    sts.comp     = rdata[srcnt_pkg::MU_COMP_BIT];
    sts.psq_fits = (psq[SQ-1:R] == '0);
    sts.q_stop   = empty | (dsq > SQ'(hi));
    sts.mu_zero  = rdata[srcnt_pkg::MU_ZERO_BIT];
    sts.div_last = (dcnt == '0);
    sts.out_busy = out_valid & ~m_axis_tready;
  end

endmodule

[hw/rtl/srcnt_ctrl.sv]
// Controller: table clear and Moebius sieve after reset, then the per-query divisor loop.
// Drives srcnt_dp through dp_cmd_t and reads dp_sts_t; depends on srcnt_pkg.
module srcnt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  srcnt_pkg::dp_sts_t sts,
  output srcnt_pkg::dp_cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_CLR      = 13'b0000000000010,
    ST_SCAN_RD  = 13'b0000000000100,
    ST_SCAN_CHK = 13'b0000000001000,
    ST_TOG_RD   = 13'b0000000010000,
    ST_TOG_WR   = 13'b0000000100000,
    ST_ZERO_RD  = 13'b0000001000000,
    ST_ZERO_WR  = 13'b0000010000000,
    ST_Q_SQ     = 13'b0000100000000,
    ST_Q_CHK    = 13'b0001000000000,
    ST_Q_DIV    = 13'b0010000000000,
    ST_Q_ACC    = 13'b0100000000000,
    ST_Q_OUT    = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = srcnt_pkg::RD_D;
    unique case (state)
      ST_CLR: begin
        if (sts.j_end) begin
          cmd.p_init = 1'b1;
          state_next = ST_SCAN_RD;
        end else begin
          cmd.wr_clr     = 1'b1;
          cmd.j_step_one = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        if (sts.p_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.rd_sel = srcnt_pkg::RD_P;
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.comp) begin
          cmd.p_inc  = 1'b1;
          state_next = ST_SCAN_RD;
        end else begin
          cmd.j_load_p = 1'b1;
          state_next   = ST_TOG_RD;
        end
      end
      ST_TOG_RD: begin
        if (sts.j_end) begin
          if (sts.psq_fits) begin
            cmd.j_load_psq = 1'b1;
            state_next     = ST_ZERO_RD;
          end else begin
            cmd.p_inc  = 1'b1;
            state_next = ST_SCAN_RD;
          end
        end else begin
          cmd.rd_sel = srcnt_pkg::RD_J;
          state_next = ST_TOG_WR;
        end
      end
      ST_TOG_WR: begin
        cmd.wr_tog   = 1'b1;
        cmd.j_step_p = 1'b1;
        state_next   = ST_TOG_RD;
      end
      ST_ZERO_RD: begin
        if (sts.j_end) begin
          cmd.p_inc  = 1'b1;
          state_next = ST_SCAN_RD;
        end else begin
          cmd.rd_sel = srcnt_pkg::RD_J;
          state_next = ST_ZERO_WR;
        end
      end
      ST_ZERO_WR: begin
        cmd.wr_zero    = 1'b1;
        cmd.j_step_psq = 1'b1;
        state_next     = ST_ZERO_RD;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.q_load = 1'b1;
          state_next = ST_Q_SQ;
        end
      end
      ST_Q_SQ: begin
        state_next = ST_Q_CHK;
      end
      ST_Q_CHK: begin
        if (sts.q_stop) begin
          state_next = ST_Q_OUT;
        end else if (sts.mu_zero) begin
          cmd.d_inc  = 1'b1;
          state_next = ST_Q_SQ;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_Q_DIV;
        end
      end
      ST_Q_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_Q_ACC;
        end
      end
      ST_Q_ACC: begin
        cmd.acc_update = 1'b1;
        cmd.d_inc      = 1'b1;
        state_next     = ST_Q_SQ;
      end
      ST_Q_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR;
      end
    endcase
  end

endmodule

[hw/rtl/squarefree_range_counter_top.sv]
// Square-free count over [range_low, range_high]; one query in flight, result in an output
// register so the next query is taken while the result waits. Each divisor d with a nonzero
// Moebius value goes through the 32-step divider, and a finished query waits while a held
// result blocks the output register. A new query is taken only after the last result is loaded
// into the output register. Reset: synchronous; clears the table and sieves it with
// s_axis_tready low.
module squarefree_range_counter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // range_low [31:0], range_high [63:32]
  input  logic [srcnt_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // squarefree_count [32:0], zero fill above
  output logic [srcnt_pkg::OUT_W-1:0] m_axis_tdata
);

  srcnt_pkg::dp_cmd_t cmd;
  srcnt_pkg::dp_sts_t sts;

  srcnt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  srcnt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[hw/rtl/srcnt_checker.sv]
// Port-level checks for squarefree_range_counter_top, attached by bind.
// Depends on srcnt_pkg for port widths.
module srcnt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [srcnt_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [srcnt_pkg::OUT_W-1:0] m_axis_tdata
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("ports not quiet after reset");

  a_one_query: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second query taken while one is in progress");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown without input side returning to ready");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind squarefree_range_counter_top srcnt_checker u_srcnt_checker (.*);
